// ===== design/rau_pkg.sv =====
// Package for the rational arithmetic unit: operation codes and word width.
// No dependencies.
`default_nettype none
package rau_pkg;
    localparam int WORD_BITS_DEF = 32;
    localparam int FIELD_BITS = 32;
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_RED = 3'd4;
endpackage
`default_nettype wire

// ===== design/rau_if.sv =====
// Valid/ready channel interfaces for the rational arithmetic unit.
// Depends on nothing but the field widths fixed here.
`default_nettype none
interface rau_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
    modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
    modport sink (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_res_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] res_num;
    logic signed [31:0] res_den;
    logic        status;
    modport source (output valid, res_num, res_den, status, input ready);
    modport sink (input valid, res_num, res_den, status, output ready);
endinterface
`default_nettype wire

// ===== design/rau_divider.sv =====
// Radix-2 restoring divider on unsigned magnitudes, one quotient bit a cycle.
// Uses rau_pkg.
`default_nettype none
module rau_divider
    import rau_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [WORD_BITS-1:0] dividend,
    input  wire logic [WORD_BITS-1:0] divisor,
    output logic                      done,
    output logic [WORD_BITS-1:0]      quo,
    output logic [WORD_BITS-1:0]      rem
);
    localparam int CW = $clog2(WORD_BITS + 1);
    logic [CW-1:0]      cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [WORD_BITS-1:0] q_reg, r_reg, d_reg;
    logic [WORD_BITS:0] trial;

    assign trial = {r_reg, q_reg[WORD_BITS-1]} - {1'b0, d_reg};
    assign quo = q_reg;
    assign rem = r_reg;
    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(WORD_BITS);
                q_reg    <= dividend;
                r_reg    <= '0;
                d_reg    <= divisor;
            end
            else if (busy_reg)
            begin
                // shift in next dividend bit, subtract if it fits
                if (!trial[WORD_BITS])
                begin
                    r_reg <= trial[WORD_BITS-1:0];
                    q_reg <= {q_reg[WORD_BITS-2:0], 1'b1};
                end
                else
                begin
                    r_reg <= {r_reg[WORD_BITS-2:0], q_reg[WORD_BITS-1]};
                    q_reg <= {q_reg[WORD_BITS-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== design/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: combine two fractions, reduce by Euclidean gcd.
// Sequence: three products (P1..P3), form n/d, then the gcd loop of remainder steps
// on the divider, loop end seen in GTEST, two final divisions of n and d by the gcd,
// then the output register. Zero over zero gives 0/0 with status set.
// One request at a time; not ready until its result enters the output register, where
// it may wait for the receiver. Throughput set by the shared bit-serial divider.
// Reset clears the sequencer and output valid; data registers are not reset.
`default_nettype none
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    rau_req_if.sink   req,
    rau_res_if.source res
);
    localparam int W = WORD_BITS;
    typedef enum logic [3:0] {
        S_IDLE, S_P1, S_P2, S_P3, S_P4, S_FORM, S_GTEST, S_GWAIT,
        S_NDIV, S_NWAIT, S_DDIV, S_DWAIT, S_OUT
    } state_t;

    state_t state_reg;
    logic [2:0]   op_reg;
    logic [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic [W-1:0] m0_reg, m1_reg, m2_reg;
    logic [W-1:0] n_reg, d_reg, x_reg, y_reg, g_reg;
    logic         out_valid_reg, status_reg;
    logic [W-1:0] rn_reg, rd_reg;

    // one shared multiplier, operands chosen by step; keep the low word only
    logic [W-1:0] mul_a, mul_b, mul_p;

    // shared divider on magnitudes
    logic         div_start, div_done;
    logic [W-1:0] div_a, div_b, div_q, div_r;

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        mag = v[W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [W-1:0] neg(input logic [W-1:0] v);
        neg = ~v + 1'b1;
    endfunction

    function automatic logic [W-1:0] ext(input logic [FIELD_BITS-1:0] v);
        logic [W+FIELD_BITS-1:0] t;
        t = {{W{v[FIELD_BITS-1]}}, v};
        ext = t[W-1:0];
    endfunction

    function automatic logic [FIELD_BITS-1:0] to_field(input logic [W-1:0] v);
        logic [W+FIELD_BITS-1:0] t;
        t = {{FIELD_BITS{v[W-1]}}, v};
        to_field = t[FIELD_BITS-1:0];
    endfunction

    always_comb
    begin
        case (state_reg)
            S_P1:    begin mul_a = an_reg; mul_b = (op_reg == OP_MUL) ? bn_reg : bd_reg; end
            S_P2:    begin mul_a = bn_reg; mul_b = ad_reg; end
            S_P3:    begin mul_a = ad_reg; mul_b = (op_reg == OP_DIV) ? bn_reg : bd_reg; end
            default: begin mul_a = an_reg; mul_b = bd_reg; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        case (state_reg)
            S_NDIV:  begin div_a = mag(n_reg); div_b = mag(g_reg); end
            S_DDIV:  begin div_a = mag(d_reg); div_b = mag(g_reg); end
            default: begin div_a = mag(x_reg); div_b = mag(y_reg); end
        endcase
    end
    assign div_start = (state_reg == S_GTEST && y_reg != '0) ||
                       state_reg == S_NDIV || state_reg == S_DDIV;

    rau_divider #(.WORD_BITS(W)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
        .divisor(div_b), .done(div_done), .quo(div_q), .rem(div_r)
    );

    assign req.ready   = (state_reg == S_IDLE);
    assign res.valid   = out_valid_reg;
    assign res.res_num = rn_reg;
    assign res.res_den = rd_reg;
    assign res.status  = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && res.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (req.valid)
                    begin
                        op_reg <= req.req_type;
                        an_reg <= ext(req.a_num);
                        ad_reg <= ext(req.a_den);
                        bn_reg <= ext(req.b_num);
                        bd_reg <= ext(req.b_den);
                        state_reg <= S_P1;
                    end
                S_P1: begin m0_reg <= mul_p; state_reg <= S_P2; end
                S_P2: begin m1_reg <= mul_p; state_reg <= S_P3; end
                S_P3: begin m2_reg <= mul_p; state_reg <= S_FORM; end
                S_FORM:
                begin
                    // assemble raw n/d; unused opcodes act as reduce
                    case (op_reg)
                        OP_ADD:  begin n_reg <= m0_reg + m1_reg; d_reg <= m2_reg; end
                        OP_SUB:  begin n_reg <= m0_reg - m1_reg; d_reg <= m2_reg; end
                        OP_MUL:  begin n_reg <= m0_reg; d_reg <= m2_reg; end
                        OP_DIV:  begin n_reg <= m0_reg; d_reg <= m2_reg; end
                        default: begin n_reg <= an_reg; d_reg <= ad_reg; end
                    endcase
                    case (op_reg)
                        OP_ADD:  begin x_reg <= m0_reg + m1_reg; y_reg <= m2_reg; end
                        OP_SUB:  begin x_reg <= m0_reg - m1_reg; y_reg <= m2_reg; end
                        OP_MUL:  begin x_reg <= m0_reg; y_reg <= m2_reg; end
                        OP_DIV:  begin x_reg <= m0_reg; y_reg <= m2_reg; end
                        default: begin x_reg <= an_reg; y_reg <= ad_reg; end
                    endcase
                    state_reg <= S_GTEST;
                end
                S_GTEST:
                    if (y_reg == '0)
                    begin
                        g_reg <= x_reg;
                        state_reg <= (x_reg == '0) ? S_P4 : S_NDIV;
                    end
                    else
                        state_reg <= S_GWAIT;
                S_GWAIT:
                    if (div_done)
                    begin
                        // remainder takes the dividend's sign
                        x_reg <= y_reg;
                        y_reg <= x_reg[W-1] ? neg(div_r) : div_r;
                        state_reg <= S_GTEST;
                    end
                S_P4:
                    if (!out_valid_reg)
                    begin
                        // zero over zero
                        rn_reg <= '0;
                        rd_reg <= '0;
                        status_reg <= 1'b1;
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                S_NDIV: state_reg <= S_NWAIT;
                S_NWAIT:
                    if (div_done)
                    begin
                        n_reg <= (n_reg[W-1] != g_reg[W-1]) ? neg(div_q) : div_q;
                        state_reg <= S_DDIV;
                    end
                S_DDIV: state_reg <= S_DWAIT;
                S_DWAIT:
                    if (div_done)
                    begin
                        d_reg <= (d_reg[W-1] != g_reg[W-1]) ? neg(div_q) : div_q;
                        state_reg <= S_OUT;
                    end
                S_OUT:
                    if (!out_valid_reg)
                    begin
                        // move sign to the numerator
                        rn_reg <= to_field(d_reg[W-1] ? neg(n_reg) : n_reg);
                        rd_reg <= to_field(d_reg[W-1] ? neg(d_reg) : d_reg);
                        status_reg <= 1'b0;
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== bench/tb_rational_arithmetic_unit.sv =====
// Testbench for the rational arithmetic unit: drives fraction requests, predicts
// the reduced results and checks every result transaction in order.
// Depends on rau_pkg and the rau_req_if / rau_res_if interfaces in design/.
`default_nettype none

class fraction_scoreboard;
    // Expected results, oldest first.
    logic [31:0] want_num[$];
    logic [31:0] want_den[$];
    logic        want_status[$];
    int          mismatches;

    function new();
        mismatches = 0;
    endfunction

    // Truncating quotient; zero divisor gives zero.
    static function logic [31:0] tdiv(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        if (mb == 0)
            return 32'd0;
        q = ma / mb;
        if (a[31] != b[31])
            q = -q;
        return q;
    endfunction

    // Truncating remainder, sign follows the dividend; zero divisor returns a.
    static function logic [31:0] trem(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] r;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        if (mb == 0)
            return a;
        r = ma % mb;
        if (a[31])
            r = -r;
        return r;
    endfunction

    // Note an accepted request: form the raw fraction, reduce it, queue the result.
    function void note_request(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                               logic [31:0] bn, logic [31:0] bd);
        logic [31:0] n;
        logic [31:0] d;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] t;
        case (op)
            rau_pkg::OP_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
            rau_pkg::OP_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
            rau_pkg::OP_MUL: begin n = an * bn; d = ad * bd; end
            rau_pkg::OP_DIV: begin n = an * bd; d = ad * bn; end
            default:         begin n = an; d = ad; end
        endcase
        x = n;
        y = d;
        while (y != 0)
        begin
            t = y;
            y = trem(x, y);
            x = t;
        end
        if (x == 0)
        begin
            want_num.push_back(32'd0);
            want_den.push_back(32'd0);
            want_status.push_back(1'b1);
            return;
        end
        n = tdiv(n, x);
        d = tdiv(d, x);
        if (d[31])
        begin
            n = -n;
            d = -d;
        end
        want_num.push_back(n);
        want_den.push_back(d);
        want_status.push_back(1'b0);
    endfunction

    // Check one accepted result against the oldest expectation.
    function void check_result(logic [31:0] num, logic [31:0] den, logic st);
        logic [31:0] en;
        logic [31:0] ed;
        logic        es;
        if (want_num.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result %h/%h status %b", num, den, st);
            return;
        end
        en = want_num.pop_front();
        ed = want_den.pop_front();
        es = want_status.pop_front();
        if (num !== en || den !== ed || st !== es)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected %h/%h status %b, got %h/%h status %b",
                         en, ed, es, num, den, st);
        end
    endfunction

    function int pending();
        return want_num.size();
    endfunction
endclass

module tb_rational_arithmetic_unit;
    import rau_pkg::*;

    localparam int LIMIT_CYCLES = 20000000;

    logic clk;
    logic rst_n;
    int   cycle_count;
    // Pace of both sides: when set, idle/stall about 30% of the time.
    logic jitter_on;

    rau_req_if req_ch ();
    rau_res_if res_ch ();

    rational_arithmetic_unit uut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch.sink),
        .res  (res_ch.source)
    );

    fraction_scoreboard board;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Bound the run; count cycles from the start.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("rational_arithmetic_unit test failed");
            $finish;
        end
    end

    // Result side: stall at random, check each accepted transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
                board.check_result(res_ch.res_num, res_ch.res_den, res_ch.status);
            res_ch.ready <= jitter_on ? ($urandom_range(0, 99) >= 30) : 1'b1;
        end
    end

    // Pick an operand: mostly small values, sometimes edges and wide randoms.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'd0;
            3, 4: return $urandom;
            5: return -$urandom_range(1, 1000);
            default: return $urandom_range(0, 1000);
        endcase
    endfunction

    // Offer one request; hold it until accepted, then note it. Valid stays
    // high after acceptance so the next call can replace the payload at the
    // same edge; idle cycles drop it.
    task automatic send_request(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                                logic [31:0] bn, logic [31:0] bd);
        // Random idle cycles before the transaction.
        while (jitter_on && $urandom_range(0, 99) < 30)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= op;
        req_ch.a_num    <= an;
        req_ch.a_den    <= ad;
        req_ch.b_num    <= bn;
        req_ch.b_den    <= bd;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        board.note_request(op, an, ad, bn, bd);
    endtask

    initial
    begin
        logic [2:0] op;
        board        = new();
        cycle_count  = 0;
        jitter_on    = 1'b0;
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = OP_ADD;
        req_ch.a_num = 0;
        req_ch.a_den = 0;
        req_ch.b_num = 0;
        req_ch.b_den = 0;
        res_ch.ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: each operation, zero over zero, zero denominator,
        // most negative over minus one, negation wrap, unused opcodes.
        send_request(OP_ADD, 1, 2, 1, 3);
        send_request(OP_SUB, 1, 2, 1, 2);
        send_request(OP_MUL, -4, 6, 3, -8);
        send_request(OP_DIV, 3, 4, 9, 8);
        send_request(OP_RED, 12, -18, 0, 0);
        send_request(OP_RED, 0, 0, 5, 5);
        send_request(OP_ADD, 0, 0, 0, 0);
        send_request(OP_RED, 7, 0, 0, 0);
        send_request(OP_RED, -7, 0, 0, 0);
        send_request(OP_RED, 32'h8000_0000, -1, 0, 0);
        send_request(OP_RED, 32'h8000_0000, 32'h8000_0000, 0, 0);
        send_request(OP_RED, -1, 32'h8000_0000, 0, 0);
        send_request(OP_RED, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
        send_request(OP_RED, 32'h8000_0000, 1, 0, 0);
        send_request(OP_MUL, 32'h8000_0000, -1, 32'hFFFF_FFFF, 1);
        send_request(OP_DIV, 5, 7, 0, 3);
        send_request(OP_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(3'd5, 10, 4, 1, 1);
        send_request(3'd6, -9, -3, 2, 2);
        send_request(3'd7, 0, -5, 3, 3);
        send_request(OP_SUB, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA);

        // Random: first stretch without idling, then random pacing.
        for (int i = 0; i < 1900; i++)
        begin
            jitter_on = (i >= 300);
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            send_request(op, pick_operand(), pick_operand(),
                         pick_operand(), pick_operand());
        end
        req_ch.valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (board.mismatches == 0)
            $display("rational_arithmetic_unit test passed");
        else
            $display("rational_arithmetic_unit test failed");
        $finish;
    end
endmodule
`default_nettype wire

// ===== rational_arithmetic_unit.f =====
design/rau_pkg.sv
design/rau_if.sv
design/rau_divider.sv
design/rational_arithmetic_unit.sv
bench/tb_rational_arithmetic_unit.sv
